@@ design/palette_subtitle_luma_blend_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the subtitle luma blend block
// Short forms for the concurrent checks, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_SUBTITLE_LUMA_BLEND_MACROS_SVH
`define PALETTE_SUBTITLE_LUMA_BLEND_MACROS_SVH

// Same-cycle implication.
`define PSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/psl_pkg.sv @@
// ----------------------------------------------------------------------------
// psl_pkg
// Types and constants shared by the subtitle luma blend modules.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned DIM_W     = 12;
  localparam int unsigned LUMA_W    = 8;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned RGBA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ENTRY_W   = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_BOX_X        = 3'd2,
    CFG_BOX_Y        = 3'd3,
    CFG_BLEND_MODE   = 3'd4
  } cfg_reg_e;

  localparam logic REQ_PALETTE  = 1'b0;
  localparam logic REQ_PIXEL    = 1'b1;
  localparam logic MODE_OVERLAY = 1'b0;
  localparam logic MODE_BITMAP  = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd720;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd576;

  // RGB to luma coefficients, scaled by 1024, plus the black offset.
  localparam logic [9:0]        COEF_R      = 10'd263;
  localparam logic [9:0]        COEF_G      = 10'd516;
  localparam logic [9:0]        COEF_B      = 10'd100;
  localparam logic [LUMA_W-1:0] LUMA_OFFSET = 8'd16;
  localparam logic [LUMA_W-1:0] ALPHA_FULL  = 8'd255;
  localparam logic [LUMA_W-1:0] NOISE_LEVEL = 8'd10;

  typedef struct packed {
    logic                 req_type;
    logic [IDX_W-1:0]     palette_index;
    logic [RGBA_W-1:0]    palette_rgba;
    logic [COORD_W-1:0]   box_col;
    logic [COORD_W-1:0]   box_row;
    logic [LUMA_W-1:0]    background_luma;
  } psl_in_t;

  typedef struct packed {
    logic [LUMA_W-1:0] blended_luma;
    logic              inside_clip;
    logic              ink_above_noise;
  } psl_out_t;

  // Pixel control that travels alongside the palette read.
  typedef struct packed {
    logic              in_range;
    logic              merged;
    logic [LUMA_W-1:0] bg;
  } psl_pix_ctl_t;

endpackage

@@ design/psl_palette.sv @@
// ----------------------------------------------------------------------------
// psl_palette
// Palette memory: converts written RGBA words to luma and alpha, registered read.
// ----------------------------------------------------------------------------
module psl_palette
  import psl_pkg::*;
#(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0]   addr_i,
  input  logic [RGBA_W-1:0]            rgba_i,
  output logic [ENTRY_W-1:0]           rd_data_o
);

  logic [ENTRY_W-1:0] mem_q [ENTRIES];
  logic [ENTRY_W-1:0] rd_data_q;
  logic [17:0]        luma_sum;
  logic [LUMA_W-1:0]  luma;

  // Weighted sum of the three color bytes, at most 879 * 255.
  assign luma_sum = 18'(COEF_R) * 18'(rgba_i[7:0]) + 18'(COEF_G) * 18'(rgba_i[15:8])
                  + 18'(COEF_B) * 18'(rgba_i[23:16]);
  assign luma     = luma_sum[17:10] + LUMA_OFFSET;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= {rgba_i[31:24], luma};
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/psl_blend.sv @@
// ----------------------------------------------------------------------------
// psl_blend
// Alpha multiply stage and output register with the clip and ink flags.
// ----------------------------------------------------------------------------
module psl_blend
  import psl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  psl_pix_ctl_t       ctl_i,
  input  logic [ENTRY_W-1:0] entry_i,
  input  logic               mode_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output psl_out_t           out_data_o
);

  logic              v3_q;
  logic              vo_q;
  logic              ld_out;
  logic              ld_mul;
  logic [LUMA_W-1:0] luma;
  logic [LUMA_W-1:0] alpha;
  logic [15:0]       ink_q;
  logic [15:0]       back_q;
  logic              merged_q;
  logic [LUMA_W-1:0] bg_q;
  logic [16:0]       sum;
  logic [LUMA_W-1:0] val;
  psl_out_t          out_d;
  psl_out_t          out_q;

  assign ld_out  = !vo_q || out_ready_i;
  assign ld_mul  = !v3_q || ld_out;
  assign ready_o = ld_mul;

  // An index beyond the palette reads as luma 0 and alpha 0.
  assign luma  = ctl_i.in_range ? entry_i[7:0]  : '0;
  assign alpha = ctl_i.in_range ? entry_i[15:8] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ld_mul) begin
        v3_q <= valid_i;
      end
      if (ld_out) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_mul) begin
      ink_q    <= luma * alpha;
      back_q   <= (ALPHA_FULL - alpha) * ctl_i.bg;
      merged_q <= ctl_i.merged;
      bg_q     <= ctl_i.bg;
    end
    if (ld_out) begin
      out_q <= out_d;
    end
  end

  assign sum = (mode_i == MODE_BITMAP) ? {1'b0, ink_q} : 17'(ink_q) + 17'(back_q);
  assign val = sum[15:8];

  always_comb begin
    out_d.blended_luma    = merged_q ? val : bg_q;
    out_d.inside_clip     = merged_q;
    out_d.ink_above_noise = merged_q && (val > NOISE_LEVEL);
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

@@ design/palette_subtitle_luma_blend.sv @@
// ----------------------------------------------------------------------------
// palette_subtitle_luma_blend
// Subtitle overlay on a luma plane through a luma and alpha palette.
// ----------------------------------------------------------------------------
// Input beats arrive on in_valid_i / in_ready_o. A beat with req_type 0 writes
// one palette entry from an RGBA word and yields no result; a beat with
// req_type 1 is a subtitle pixel and yields exactly one result beat on
// out_valid_o / out_ready_i. Results leave in the order the pixels came in.
// Configuration registers are written through cfg_valid_i / cfg_index_i /
// cfg_data_i, which is always ready; write them only while the block is idle.
// The pipeline has four register stages: input, palette read and clip check,
// alpha multiplies, output register. A pixel passes through them in that order,
// and one beat per cycle is taken and given while the receiver does not stall.
// The palette memory is written and read in the same stage, so a pixel that
// follows a palette write directly already sees the new entry.
// Reset clears the valid bits and loads the register defaults; the palette
// content is undefined until written. When the receiver stalls, each stage
// keeps its beat and takes a new one only once it has moved on, so bubbles
// fill up and in_ready_o falls only when all four stages hold a beat.
// ----------------------------------------------------------------------------
`include "palette_subtitle_luma_blend_macros.svh"

module palette_subtitle_luma_blend
  import psl_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned COORD_BITS      = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psl_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output psl_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  localparam int unsigned AddrW     = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CoordUsed = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] CoordMask = COORD_W'((1 << CoordUsed) - 1);

  // Configuration registers.
  logic [DIM_W-1:0] frame_width_q;
  logic [DIM_W-1:0] frame_height_q;
  logic [DIM_W-1:0] box_x_q;
  logic [DIM_W-1:0] box_y_q;
  logic             blend_mode_q;

  // Stage 1: registered input beat.
  logic               v1_q;
  logic               s1_pix_q;
  logic [IDX_W-1:0]   s1_idx_q;
  logic               s1_in_range_q;
  logic [RGBA_W-1:0]  s1_rgba_q;
  logic [COORD_W-1:0] s1_col_q;
  logic [COORD_W-1:0] s1_row_q;
  logic [LUMA_W-1:0]  s1_bg_q;

  // Stage 2: palette read data and pixel control.
  logic               v2_q;
  psl_pix_ctl_t       s2_ctl_q;
  psl_pix_ctl_t       s2_ctl_d;

  logic               ld1;
  logic               ld2;
  logic               ld3;
  logic               in_range;
  logic [DIM_W:0]     pos_x;
  logic [DIM_W:0]     pos_y;
  logic [ENTRY_W-1:0] entry;
  logic               s1_write;
  logic               out_ink;
  logic               pipe_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      box_x_q        <= '0;
      box_y_q        <= '0;
      blend_mode_q   <= MODE_OVERLAY;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_BOX_X:        box_x_q        <= cfg_data_i;
        CFG_BOX_Y:        box_y_q        <= cfg_data_i;
        CFG_BLEND_MODE:   blend_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Each stage loads when it is empty or its beat moves on.
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;

  assign in_range = {1'b0, in_data_i.palette_index} < (IDX_W + 1)'(PALETTE_ENTRIES);

  // Stage 1 holds a palette write.
  assign s1_write = v1_q && (s1_pix_q == REQ_PALETTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= in_valid_i;
      end
      // Palette writes end here and never reach the output.
      if (ld2) begin
        v2_q <= v1_q && (s1_pix_q == REQ_PIXEL);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_pix_q      <= in_data_i.req_type;
      s1_idx_q      <= in_data_i.palette_index;
      s1_in_range_q <= in_range;
      s1_rgba_q     <= in_data_i.palette_rgba;
      s1_col_q      <= in_data_i.box_col & CoordMask;
      s1_row_q      <= in_data_i.box_row & CoordMask;
      s1_bg_q       <= in_data_i.background_luma;
    end
    if (ld2) begin
      s2_ctl_q <= s2_ctl_d;
    end
  end

  // Clip test: the box must start inside the frame and the pixel must land
  // within its width and height.
  assign pos_x = {1'b0, box_x_q} + {1'b0, s1_col_q};
  assign pos_y = {1'b0, box_y_q} + {1'b0, s1_row_q};

  always_comb begin
    s2_ctl_d.in_range = s1_in_range_q;
    s2_ctl_d.bg       = s1_bg_q;
    s2_ctl_d.merged   = (box_x_q <= frame_width_q) && (box_y_q <= frame_height_q)
                     && (pos_x < {1'b0, frame_width_q})
                     && (pos_y < {1'b0, frame_height_q});
  end

  psl_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (ld2 && s1_write && s1_in_range_q),
    .rd_en_i   (ld2 && v1_q && (s1_pix_q == REQ_PIXEL) && s1_in_range_q),
    .addr_i    (s1_idx_q[AddrW-1:0]),
    .rgba_i    (s1_rgba_q),
    .rd_data_o (entry)
  );

  psl_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v2_q),
    .ctl_i       (s2_ctl_q),
    .entry_i     (entry),
    .mode_i      (blend_mode_q),
    .ready_o     (ld3),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Terms for the checks below.
  assign out_ink   = out_valid_o && out_data_o.ink_above_noise;
  assign pipe_full = v1_q && v2_q && out_valid_o && !out_ready_i;

  `PSL_ASSERT_NEXT(a_write_no_result, s1_write && ld2, !v2_q, "palette write made a result")
  `PSL_ASSERT_NOW(a_ink_needs_clip, out_ink, out_data_o.inside_clip, "ink flag on unmerged pixel")
  `PSL_ASSERT_NOW(a_stall_only_full, !in_ready_o, pipe_full, "input stalled with a bubble inside")

endmodule

@@ bench/tb_palette_subtitle_luma_blend.sv @@
// ----------------------------------------------------------------------------
// tb_palette_subtitle_luma_blend
// Self-checking bench for the palette based subtitle luma overlay.
// A queue of input beats feeds a clocked driver. Every accepted beat runs
// through a bit-accurate predictor that keeps its own palette and register
// copy. A clocked monitor checks each result beat against the oldest
// prediction. Both sides idle at random, except in one phase that runs
// without gaps. The registers are rewritten between phases, only while idle.
// ----------------------------------------------------------------------------
module tb_palette_subtitle_luma_blend;
  timeunit 1ns;
  timeprecision 1ps;

  import psl_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  // Four register stages; twice that covers palette writes still in flight.
  localparam int unsigned PIPE_DRAIN   = 8;
  localparam int unsigned TIMEOUT_NS   = 4_000_000;
  localparam int unsigned COORD_MAX    = (1 << COORD_W) - 1;
  localparam int unsigned IDLE_PERCENT = 10;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_BEATS  = 190;
  // Register indexes past the end of the list; the block must ignore them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_BLEND_MODE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // Stimulus side. Everything starts at a known value.
  logic                 in_valid  = 1'b0;
  psl_in_t              in_beat   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  logic     in_ready;
  logic     out_valid;
  psl_out_t out_beat;
  logic     cfg_ready;

  palette_subtitle_luma_blend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Beats waiting to be driven, and blended pixels waiting to come out.
  psl_in_t  pending_beats[$];
  psl_out_t expected_pixels[$];

  // Predictor state: palette entries as {alpha, luma} and the register copy.
  logic [ENTRY_W-1:0] palette_shadow [256];
  int unsigned        cfg_width  = 32'(FRAME_WIDTH_RST);
  int unsigned        cfg_height = 32'(FRAME_HEIGHT_RST);
  int unsigned        cfg_box_x  = 0;
  int unsigned        cfg_box_y  = 0;
  logic               cfg_mode   = MODE_OVERLAY;

  // Palette entries that the stimulus has written so far. A pixel only ever
  // names one of these, since an unwritten entry has no defined content.
  bit          stocked [256];
  logic [7:0]  stocked_list[$];

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;
  // Set by the acceptance logic at the rising edge, consumed at the falling one.
  bit in_accepted = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned palette_beats  = 0;
  int unsigned merged_pixels  = 0;
  int unsigned clipped_pixels = 0;
  int unsigned checked_pixels = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Works out what one accepted beat does: a palette write updates the shadow
  // palette, a pixel pushes the blended result it must produce.
  function automatic void predict_blend(psl_in_t b);
    int unsigned red, green, blue, luma, alpha, bg, val;
    logic        merged;
    psl_out_t    res;
    if (b.req_type == REQ_PALETTE) begin
      red   = 32'(b.palette_rgba[7:0]);
      green = 32'(b.palette_rgba[15:8]);
      blue  = 32'(b.palette_rgba[23:16]);
      luma  = ((COEF_R * red + COEF_G * green + COEF_B * blue) >> 10) + LUMA_OFFSET;
      alpha = 32'(b.palette_rgba[31:24]);
      palette_shadow[b.palette_index] = {alpha[7:0], luma[7:0]};
      palette_beats++;
    end else begin
      luma  = 32'(palette_shadow[b.palette_index][7:0]);
      alpha = 32'(palette_shadow[b.palette_index][15:8]);
      bg    = 32'(b.background_luma);
      // The box itself must start inside the frame, and so must the pixel.
      merged = (cfg_box_x <= cfg_width) && (cfg_box_y <= cfg_height) &&
               (cfg_box_x + b.box_col < cfg_width) &&
               (cfg_box_y + b.box_row < cfg_height);
      if (!merged) begin
        // Outside the clip region the background passes through untouched.
        res.blended_luma    = bg[7:0];
        res.inside_clip     = 1'b0;
        res.ink_above_noise = 1'b0;
        clipped_pixels++;
      end else begin
        if (cfg_mode == MODE_OVERLAY) val = (luma * alpha + (ALPHA_FULL - alpha) * bg) >> 8;
        else val = (luma * alpha) >> 8;
        res.blended_luma    = val[7:0];
        res.inside_clip     = 1'b1;
        res.ink_above_noise = (val[7:0] > NOISE_LEVEL);
        merged_pixels++;
      end
      expected_pixels.push_back(res);
    end
  endfunction

  // Input driver. A beat is taken at a rising edge with valid and ready high;
  // the next one, or an idle cycle, is set up at the following falling edge.
  always @(posedge clk_i) begin
    if (rst_n && in_valid && in_ready) begin
      predict_blend(in_beat);
      void'(pending_beats.pop_front());
      in_accepted = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_n && (!in_valid || in_accepted)) begin
      in_accepted = 1'b0;
      if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
        in_valid <= 1'b1;
        in_beat  <= pending_beats[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, independently of the sender.
  always @(negedge clk_i) begin
    out_ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PERCENT);
  end

  // Monitor: every result beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    psl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result beat with no pixel pending (luma %0d)",
                                  out_beat.blended_luma));
      end else begin
        want = expected_pixels.pop_front();
        checked_pixels++;
        if (out_beat.blended_luma !== want.blended_luma)
          report_mismatch($sformatf("pixel %0d blended_luma %0d, expected %0d",
                                    checked_pixels, out_beat.blended_luma,
                                    want.blended_luma));
        if (out_beat.inside_clip !== want.inside_clip)
          report_mismatch($sformatf("pixel %0d inside_clip %0b, expected %0b",
                                    checked_pixels, out_beat.inside_clip,
                                    want.inside_clip));
        if (out_beat.ink_above_noise !== want.ink_above_noise)
          report_mismatch($sformatf("pixel %0d ink_above_noise %0b, expected %0b",
                                    checked_pixels, out_beat.ink_above_noise,
                                    want.ink_above_noise));
      end
    end
  end

  // One register write beat. The shadow copy follows the same decode.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  cfg_width  = 32'(value);
      CFG_FRAME_HEIGHT: cfg_height = 32'(value);
      CFG_BOX_X:        cfg_box_x  = 32'(value);
      CFG_BOX_Y:        cfg_box_y  = 32'(value);
      CFG_BLEND_MODE:   cfg_mode   = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [DIM_W-1:0] width, logic [DIM_W-1:0] height,
                            logic [DIM_W-1:0] box_x, logic [DIM_W-1:0] box_y,
                            logic [DIM_W-1:0] mode);
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    write_reg(CFG_BOX_X, box_x);
    write_reg(CFG_BOX_Y, box_y);
    write_reg(CFG_BLEND_MODE, mode);
  endtask

  // Waits until every beat is in and every pixel is out, then lets the
  // pipeline drain so that trailing palette writes have landed as well.
  task automatic wait_idle();
    do @(negedge clk_i); while (pending_beats.size() != 0 || expected_pixels.size() != 0);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // Unused fields of a beat carry random bits so that every input bit toggles.
  function automatic void queue_palette(logic [7:0] idx, logic [31:0] rgba);
    psl_in_t b;
    b.req_type        = REQ_PALETTE;
    b.palette_index   = idx;
    b.palette_rgba    = rgba;
    b.box_col         = COORD_W'($urandom);
    b.box_row         = COORD_W'($urandom);
    b.background_luma = LUMA_W'($urandom);
    pending_beats.push_back(b);
    if (!stocked[idx]) begin
      stocked[idx] = 1'b1;
      stocked_list.push_back(idx);
    end
  endfunction

  function automatic void queue_pixel(logic [7:0] idx, logic [COORD_W-1:0] col,
                                      logic [COORD_W-1:0] row, logic [7:0] bg);
    psl_in_t b;
    b.req_type        = REQ_PIXEL;
    b.palette_index   = idx;
    b.palette_rgba    = $urandom;
    b.box_col         = col;
    b.box_row         = row;
    b.background_luma = bg;
    pending_beats.push_back(b);
  endfunction

  // Mostly coordinates up to and just past the clip edge, so that merged and
  // clipped pixels mix; now and then anything in the field's range.
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned dim, int unsigned origin);
    int unsigned span;
    span = (dim > origin) ? dim - origin : 0;
    if (span > COORD_MAX) span = COORD_MAX;
    if ($urandom_range(9) < 8) return COORD_W'($urandom_range(span));
    return COORD_W'($urandom_range(COORD_MAX));
  endfunction

  task automatic queue_random_beat();
    logic [31:0] rgba;
    logic [7:0]  bg;
    if ($urandom_range(3) == 0) begin
      rgba = $urandom;
      case ($urandom_range(7))
        0: rgba[31:24] = 8'h00;
        1: rgba[31:24] = 8'hFF;
        default: ;
      endcase
      queue_palette(8'($urandom_range(255)), rgba);
    end else begin
      bg = 8'($urandom);
      case ($urandom_range(15))
        0: bg = 8'h00;
        1: bg = 8'hFF;
        default: ;
      endcase
      queue_pixel(stocked_list[$urandom_range(stocked_list.size() - 1)],
                  pick_coord(cfg_width, cfg_box_x), pick_coord(cfg_height, cfg_box_y), bg);
    end
  endtask

  initial begin
    int unsigned      phase;
    logic [DIM_W-1:0] width, height, box_x, box_y, mode;

    rst_n = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Directed part, first under the reset register values.
    queue_palette(8'h00, 32'h0000_0000);   // darkest luma, fully transparent
    queue_palette(8'hFF, 32'hFFFF_FFFF);   // brightest luma, fully opaque
    queue_palette(8'h55, 32'h55AA_55AA);
    queue_palette(8'hAA, 32'hAA55_AA55);
    queue_palette(8'h0F, 32'hA000_0000);   // bitmap value lands exactly on 10
    queue_palette(8'hF0, 32'hB000_0000);   // bitmap value lands on 11
    queue_pixel(8'hFF, 12'd0, 12'd0, 8'h00);
    queue_pixel(8'h00, 12'd719, 12'd575, 8'hFF);   // last merged corner
    queue_pixel(8'hFF, 12'd720, 12'd0, 8'h5A);     // one column past the edge
    queue_pixel(8'h00, 12'd0, 12'd576, 8'hA5);     // one line past the edge
    queue_pixel(8'h55, 12'hFFF, 12'hFFF, 8'h33);
    // A pixel that reads the entry written by the beat just before it.
    queue_palette(8'h3C, 32'h8020_4060);
    queue_pixel(8'h3C, 12'd10, 12'd20, 8'h80);
    wait_idle();

    // Largest frame in bitmap mode; the mode register ignores its upper bits.
    set_config(12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'hFFF);
    for (int unsigned i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++) begin
      write_reg(CFG_IDX_W'(i), 12'hFFF);
    end
    queue_pixel(8'h0F, 12'd5, 12'd5, 8'hFF);       // at the noise level, no ink
    queue_pixel(8'hF0, 12'd5, 12'd5, 8'hFF);       // just above it
    queue_pixel(8'hFF, 12'd4094, 12'd4094, 8'h00);
    queue_pixel(8'hFF, 12'd4095, 12'd0, 8'h00);
    wait_idle();

    // Box starting below the frame: nothing merges.
    set_config(12'd200, 12'd50, 12'd150, 12'd60, 12'd0);
    queue_pixel(8'hAA, 12'd0, 12'd0, 8'h11);
    wait_idle();

    // Box in the very last pixel of the frame.
    set_config(12'd200, 12'd50, 12'd199, 12'd49, 12'd0);
    queue_pixel(8'hAA, 12'd0, 12'd0, 8'h22);
    queue_pixel(8'hAA, 12'd1, 12'd0, 8'h22);
    queue_pixel(8'hAA, 12'd0, 12'd1, 8'h22);
    wait_idle();

    // Random phases, each under its own register setting.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: begin
          width = FRAME_WIDTH_RST; height = FRAME_HEIGHT_RST;
          box_x = 12'd0; box_y = 12'd0; mode = 12'd0;
        end
        1: begin
          width = 12'hFFF; height = 12'hFFF; box_x = 12'd0; box_y = 12'd0; mode = 12'd1;
        end
        2: begin
          // Empty frame: every pixel falls outside.
          width = 12'd0; height = 12'd0; box_x = 12'd0; box_y = 12'd0;
          mode = DIM_W'($urandom);
        end
        3: begin
          width = 12'd720; height = 12'd576; box_x = 12'd600; box_y = 12'd500; mode = 12'd1;
        end
        default: begin
          width  = DIM_W'($urandom_range(COORD_MAX));
          height = DIM_W'($urandom_range(COORD_MAX));
          box_x  = ($urandom_range(3) == 0) ? DIM_W'($urandom_range(COORD_MAX))
                                            : DIM_W'($urandom_range(32'(width)));
          box_y  = ($urandom_range(3) == 0) ? DIM_W'($urandom_range(COORD_MAX))
                                            : DIM_W'($urandom_range(32'(height)));
          mode   = DIM_W'($urandom);
        end
      endcase
      set_config(width, height, box_x, box_y, mode);
      steady = (phase == 4);
      repeat (PHASE_BEATS) queue_random_beat();
      wait_idle();
    end
    steady = 1'b0;

    $display("Checked %0d pixels (%0d merged, %0d clipped) and %0d palette writes,",
             checked_pixels, merged_pixels, clipped_pixels, palette_beats);
    $display("over %0d register settings incl. empty and full-size frames.", RAND_PHASES + 4);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("[%0t] Timeout with %0d beats unsent and %0d pixels outstanding",
             $realtime, pending_beats.size(), expected_pixels.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/psl_pkg.sv
design/psl_palette.sv
design/psl_blend.sv
design/palette_subtitle_luma_blend.sv
bench/tb_palette_subtitle_luma_blend.sv
